@@ design/skst_pkg.sv @@
// ----------------------------------------------------------------------------
// skst_pkg
// Types and codes shared by the sorted key set table.
// ----------------------------------------------------------------------------
package skst_pkg;

    localparam logic [2:0] OP_INSERT    = 3'd0;
    localparam logic [2:0] OP_DELETE    = 3'd1;
    localparam logic [2:0] OP_SEARCH    = 3'd2;
    localparam logic [2:0] OP_LIST_ASC  = 3'd3;
    localparam logic [2:0] OP_LIST_DESC = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUP       = 3'd1;
    localparam logic [2:0] ST_NOTFOUND  = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] key;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] key_out;
        logic [5:0]         position;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic valid;
        req_t req;
    } queue_t;

endpackage

@@ design/sorted_key_set_table_core.sv @@
// ----------------------------------------------------------------------------
// sorted_key_set_table_core
// Sorted set of distinct signed keys with insert, delete, search and listing.
// ----------------------------------------------------------------------------
// Requests enter a two-deep queue and are executed against a row of CAPACITY
// compare cells; insert, delete and search give one result each, valid after
// the edge that takes the request from the queue. A listing first starts, then
// gives one result per stored key, one per cycle while results are popped, out
// of the single result register; on an empty table it gives one empty result.
// The next request waits until the listing is done. A result that is not
// popped stalls the back end, and the input stalls once the queue holds two
// requests. Unknown opcodes are accepted and dropped with no result.
module sorted_key_set_table_core
#(
    parameter int CAPACITY = 32
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  skst_pkg::req_t request,
    output logic           empty,
    input  logic           pop,
    output skst_pkg::rsp_t result
);
    import skst_pkg::*;

    queue_t head;
    logic   take;

    skst_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .request (request),
        .head    (head),
        .take    (take)
    );

    skst_back #(
        .CAPACITY (CAPACITY)
    ) u_back
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .take   (take),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

@@ design/skst_front.sv @@
// ----------------------------------------------------------------------------
// skst_front
// Request intake: drops unknown opcodes and queues the rest for the back end.
// ----------------------------------------------------------------------------
module skst_front
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  skst_pkg::req_t request,
    output skst_pkg::queue_t head,
    input  logic           take
);
    import skst_pkg::*;

    localparam int DEPTH = 2;

    req_t       slot_reg [DEPTH];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] fill_reg;
    logic [1:0] fill_next;
    logic       known_op;
    logic       wr_en;
    logic       rd_en;

    assign full     = (fill_reg == 2'(DEPTH));
    assign known_op = (request.opcode <= OP_LIST_DESC);
    assign wr_en    = push && !full && known_op;
    assign rd_en    = take && (fill_reg != 2'd0);

    assign head.valid = (fill_reg != 2'd0);
    assign head.req   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ wr_en;
        rd_ptr_next = rd_ptr_reg ^ rd_en;
        fill_next   = fill_reg + 2'(wr_en) - 2'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_reg[wr_ptr_reg] <= request;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ design/skst_back.sv @@
// ----------------------------------------------------------------------------
// skst_back
// Execution: sorted cell row, listing sequencer and result register.
// ----------------------------------------------------------------------------
module skst_back
#(
    parameter int CAPACITY = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  skst_pkg::queue_t head,
    output logic             take,
    output logic             empty,
    input  logic             pop,
    output skst_pkg::rsp_t   result
);
    import skst_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_LIST = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic signed [31:0] cells_reg [CAPACITY];
    logic signed [31:0] cells_next [CAPACITY];
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      count_next;
    logic [CW-1:0]      ptr_reg;
    logic [CW-1:0]      ptr_next;
    logic               desc_reg;
    logic               desc_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    rsp_t               out_reg;
    rsp_t               out_next;
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] eq;
    logic               found;
    logic               out_ready;
    logic               list_last;
    logic [6:0]         rank_wide;
    logic signed [31:0] list_key;

    assign out_ready = !out_valid_reg || pop;
    assign take      = (state_reg == S_RUN) && head.valid && out_ready;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;
    assign found     = |eq;
    assign rank_wide = 7'(ptr_reg) + 7'd1;
    assign list_key  = cells_reg[ptr_reg[IW-1:0]];
    assign list_last = desc_reg ? (ptr_reg == '0) : (ptr_reg == count_reg - CW'(1));

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            lt[i] = (CW'(i) < count_reg) && (cells_reg[i] < head.req.key);
            eq[i] = (CW'(i) < count_reg) && (cells_reg[i] == head.req.key);
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        desc_next      = desc_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        for (int i = 0; i < CAPACITY; i++)
        begin
            cells_next[i] = cells_reg[i];
        end

        unique case (state_reg)
            S_RUN:
            begin
                if (take)
                begin
                    out_valid_next    = 1'b1;
                    out_next.status   = ST_OK;
                    out_next.key_out  = head.req.key;
                    out_next.position = 6'd0;
                    out_next.last     = 1'b1;
                    unique case (head.req.opcode) inside
                        OP_INSERT:
                        begin
                            if (found)
                            begin
                                out_next.status = ST_DUP;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                out_next.status = ST_FULL;
                            end
                            else
                            begin
                                count_next = count_reg + CW'(1);
                                for (int i = 0; i < CAPACITY; i++)
                                begin
                                    if (!lt[i])
                                    begin
                                        if (i == 0)
                                        begin
                                            cells_next[i] = head.req.key;
                                        end
                                        else if (lt[(i > 0) ? i - 1 : 0])
                                        begin
                                            cells_next[i] = head.req.key;
                                        end
                                        else
                                        begin
                                            cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                                        end
                                    end
                                end
                            end
                        end
                        OP_DELETE, OP_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status = ST_EMPTY;
                            end
                            else if (!found)
                            begin
                                out_next.status = ST_NOTFOUND;
                            end
                            else if (head.req.opcode == OP_DELETE)
                            begin
                                count_next = count_reg - CW'(1);
                                for (int i = 0; i < CAPACITY - 1; i++)
                                begin
                                    if (!lt[i])
                                    begin
                                        cells_next[i] = cells_reg[i + 1];
                                    end
                                end
                            end
                        end
                        default:
                        begin
                            if (count_reg == '0)
                            begin
                                out_next.status  = ST_EMPTY;
                                out_next.key_out = '0;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && !pop;
                                out_next       = out_reg;
                                state_next     = S_LIST;
                                desc_next      = (head.req.opcode == OP_LIST_DESC);
                                ptr_next       = (head.req.opcode == OP_LIST_DESC) ?
                                                 count_reg - CW'(1) : '0;
                            end
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                if (out_ready)
                begin
                    out_valid_next    = 1'b1;
                    out_next.status   = ST_OK;
                    out_next.key_out  = list_key;
                    out_next.position = rank_wide[5:0];
                    out_next.last     = list_last;
                    if (list_last)
                    begin
                        state_next = S_RUN;
                    end
                    else
                    begin
                        ptr_next = desc_reg ? ptr_reg - CW'(1) : ptr_reg + CW'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            cells_reg[i] <= cells_next[i];
        end
        out_reg  <= out_next;
        ptr_reg  <= ptr_next;
        desc_reg <= desc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> (count_reg != '0))
        else $error("listing an empty table");

    a_list_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |=> $stable(count_reg))
        else $error("table changed during listing");

    a_take_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        take |-> (state_reg == S_RUN) && (!out_valid_reg || pop))
        else $error("request taken without result room");
`endif

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for sorted_key_set_table_core. Requests go in through
// the push side, results are popped and compared field by field with a
// predicted table. Covers the corner cases, a full table and random traffic
// with several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;

    import skst_pkg::*;

    localparam int CAPACITY = 32;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    req_t request = '0;
    logic empty;
    logic pop = 1'b0;
    rsp_t result;

    logic signed [31:0] table_keys [CAPACITY];
    int table_count = 0;
    rsp_t expected_results [$];
    int mismatch_count = 0;
    int send_idle_pct = 0;
    int pop_stall_pct = 0;

    sorted_key_set_table_core #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .request(request),
        .empty(empty),
        .pop(pop),
        .result(result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic rsp_t make_result(logic [2:0] st, logic signed [31:0] k,
                                         logic [5:0] pos, logic lst);
        rsp_t r;
        r.status = st;
        r.key_out = k;
        r.position = pos;
        r.last = lst;
        return r;
    endfunction

    task automatic predict_request(input req_t r);
        logic signed [31:0] k;
        int idx;
        int slot;
        k = r.key;
        idx = 0;
        while (idx < table_count && table_keys[idx] != k)
            idx++;
        case (r.opcode) inside
            OP_INSERT:
            begin
                if (idx < table_count)
                    expected_results.push_back(make_result(ST_DUP, k, 6'd0, 1'b1));
                else if (table_count >= CAPACITY)
                    expected_results.push_back(make_result(ST_FULL, k, 6'd0, 1'b1));
                else
                begin
                    idx = 0;
                    while (idx < table_count && table_keys[idx] < k)
                        idx++;
                    for (int i = table_count; i > idx; i--)
                        table_keys[i] = table_keys[i - 1];
                    table_keys[idx] = k;
                    table_count++;
                    expected_results.push_back(make_result(ST_OK, k, 6'd0, 1'b1));
                end
            end
            OP_DELETE, OP_SEARCH:
            begin
                if (table_count == 0)
                    expected_results.push_back(make_result(ST_EMPTY, k, 6'd0, 1'b1));
                else if (idx >= table_count)
                    expected_results.push_back(make_result(ST_NOTFOUND, k, 6'd0, 1'b1));
                else
                begin
                    if (r.opcode == OP_DELETE)
                    begin
                        for (int i = idx; i + 1 < table_count; i++)
                            table_keys[i] = table_keys[i + 1];
                        table_count--;
                    end
                    expected_results.push_back(make_result(ST_OK, k, 6'd0, 1'b1));
                end
            end
            OP_LIST_ASC, OP_LIST_DESC:
            begin
                if (table_count == 0)
                    expected_results.push_back(make_result(ST_EMPTY, 32'sd0, 6'd0, 1'b1));
                else
                    for (int i = 0; i < table_count; i++)
                    begin
                        slot = (r.opcode == OP_LIST_ASC) ? i : table_count - 1 - i;
                        expected_results.push_back(make_result(ST_OK, table_keys[slot],
                            6'(slot + 1), i + 1 == table_count));
                    end
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input rsp_t got, input rsp_t exp);
        $display("%0t mismatch (%s): got st=%0d key=%0d pos=%0d last=%0b, %s",
                 $time, what, got.status, got.key_out, got.position, got.last,
                 $sformatf("exp st=%0d key=%0d pos=%0d last=%0b",
                           exp.status, exp.key_out, exp.position, exp.last));
        mismatch_count++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        rsp_t exp;
        if (rst_n && pop && !empty)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", result, '0);
            else
            begin
                exp = expected_results.pop_front();
                if (result.status !== exp.status || result.key_out !== exp.key_out ||
                    result.position !== exp.position || result.last !== exp.last)
                    report_mismatch("field", result, exp);
            end
        end
    end

    always @(negedge clk)
    begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    task automatic send_request(input logic [2:0] op, input logic signed [31:0] k);
        req_t r;
        int gap;
        r.opcode = op;
        r.key = k;
        @(negedge clk);
        push <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (full);
        predict_request(r);
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(9))
            0: return 32'sh8000_0000 + $urandom_range(3);
            1: return 32'sh7fff_ffff - $urandom_range(3);
            2: return $urandom;
            default: return $signed(32'($urandom_range(23))) - 32'sd12;
        endcase
    endfunction

    task automatic test_corner_cases();
        send_request(OP_LIST_ASC, 32'sd5);
        send_request(OP_LIST_DESC, -32'sd5);
        send_request(OP_DELETE, 32'sd0);
        send_request(OP_SEARCH, 32'sh8000_0000);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_INSERT, 32'sh8000_0000);
        send_request(OP_INSERT, 32'sh7fff_ffff);
        send_request(OP_INSERT, -32'sd1);
        send_request(OP_INSERT, 32'sd1);
        send_request(OP_INSERT, 32'sd0);
        send_request(OP_SEARCH, 32'sh7fff_ffff);
        send_request(OP_SEARCH, 32'sd5);
        send_request(OP_LIST_ASC, 32'sd0);
        send_request(OP_LIST_DESC, 32'shffff_ffff);
        send_request(OP_DELETE, 32'sh8000_0000);
        send_request(OP_DELETE, 32'sd7);
        send_request(3'd5, 32'sh5555_5555);
        send_request(3'd6, 32'shaaaa_aaaa);
        send_request(3'd7, 32'sd1);
        send_request(OP_LIST_ASC, 32'sd0);
    endtask

    task automatic test_full_table();
        logic signed [31:0] snapshot [CAPACITY];
        int n;
        int cnt;
        n = 0;
        while (table_count < CAPACITY)
        begin
            send_request(OP_INSERT, $signed(32'h1000_0000 + n * 32'h0101_0103));
            n++;
        end
        send_request(OP_INSERT, 32'sh7fff_fff0);
        send_request(OP_INSERT, table_keys[0]);
        send_request(OP_LIST_ASC, 32'sd0);
        send_request(OP_LIST_DESC, 32'sd0);
        snapshot = table_keys;
        cnt = table_count;
        for (int i = 0; i < 8; i++)
            send_request(OP_DELETE, snapshot[(i * 7) % cnt]);
        send_request(OP_LIST_DESC, 32'sd0);
    endtask

    task automatic test_random_traffic(input int items);
        int done;
        int pick;
        done = 0;
        while (done < items)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_request(OP_INSERT, pick_key());
            else if (pick < 60)
                send_request(OP_DELETE, pick_key());
            else if (pick < 80)
                send_request(OP_SEARCH, pick_key());
            else if (pick < 86)
                send_request(OP_LIST_ASC, $urandom);
            else if (pick < 92)
                send_request(OP_LIST_DESC, $urandom);
            else
                send_request(3'($urandom_range(7, 5)), $urandom);
            if (pick < 92)
                done++;
        end
    endtask

    initial
    begin
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        test_corner_cases();

        send_idle_pct = 35;
        pop_stall_pct = 35;
        test_full_table();

        send_idle_pct = 0;
        pop_stall_pct = 0;
        test_random_traffic(12);
        send_idle_pct = 57;
        pop_stall_pct = 0;
        test_random_traffic(12);
        send_idle_pct = 0;
        pop_stall_pct = 57;
        test_random_traffic(12);
        send_idle_pct = 35;
        pop_stall_pct = 35;
        test_random_traffic(12);

        @(negedge clk);
        push <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sorted_key_set_table_core.f @@
design/skst_pkg.sv
design/skst_front.sv
design/skst_back.sv
design/sorted_key_set_table_core.sv
test/testbench.sv
